/* hdl/caw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caw_pkg: shared types and constants for the CIGAR alignment walker
// Holds the payload structs, command/kind/status codes, CIGAR character
// codes and position helpers.
// ----------------------------------------------------------------------------
package caw_pkg;

  // Width of the reference cursor; reported positions are 32 bits.
  localparam int unsigned POS_BITS = 32;
  localparam int unsigned CNT_BITS = 32;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_MAPPED   = 2'd0,
    KIND_UNMAPPED = 2'd1,
    KIND_SUMMARY  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_COUNT    = 3'd1,
    ST_MATCH_CLIP  = 3'd2,
    ST_INSERT_CLIP = 3'd3,
    ST_DELETE_CLIP = 3'd4,
    ST_SOFT_HARD   = 3'd5,
    ST_UNKNOWN_OP  = 3'd6,
    ST_TRAILING    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    OPC_DIGIT   = 3'd0,
    OPC_MATCH   = 3'd1,
    OPC_INSERT  = 3'd2,
    OPC_DELETE  = 3'd3,
    OPC_SOFT    = 3'd4,
    OPC_HARD    = 3'd5,
    OPC_PAD     = 3'd6,
    OPC_UNKNOWN = 3'd7
  } opc_e;

  // ASCII CIGAR characters
  localparam logic [7:0] CH_0  = 8'd48;
  localparam logic [7:0] CH_9  = 8'd57;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_X  = 8'h58;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] start_position;
    logic [7:0]  symbol;
  } caw_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_pos;
    logic [31:0] ref_pos;
    logic [31:0] run_length;
    logic [31:0] clip_front;
    logic [31:0] clip_back;
    logic [2:0]  status;
  } caw_out_t;

  // Zero-extend or truncate a cursor value to the 32-bit result field.
  function automatic logic [31:0] pos_to_out(input logic [POS_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

  // Bring a 32-bit start coordinate into cursor width.
  function automatic logic [POS_BITS-1:0] pos_from_in(input logic [31:0] s);
    logic [63:0] w;
    w = 64'(s);
    return w[POS_BITS-1:0];
  endfunction

endpackage

/* hdl/caw_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caw_decode: CIGAR character classifier
// Maps one ASCII character to an operation class and a digit value.
// ----------------------------------------------------------------------------
module caw_decode (
  input  logic [7:0]          symbol_i,
  output caw_pkg::opc_e       opc_o,
  output logic [3:0]          digit_o
);
  import caw_pkg::*;

  logic [7:0] offset;

  assign offset  = symbol_i - CH_0;
  assign digit_o = offset[3:0];

  always_comb begin
    if (symbol_i >= CH_0 && symbol_i <= CH_9) begin
      opc_o = OPC_DIGIT;
    end else begin
      case (symbol_i)
        CH_M, CH_EQ, CH_X: opc_o = OPC_MATCH;
        CH_I:              opc_o = OPC_INSERT;
        CH_D, CH_N:        opc_o = OPC_DELETE;
        CH_S:              opc_o = OPC_SOFT;
        CH_H:              opc_o = OPC_HARD;
        CH_P:              opc_o = OPC_PAD;
        default:           opc_o = OPC_UNKNOWN;
      endcase
    end
  end

endmodule

/* hdl/caw_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caw_walk: CIGAR walk state and per-item step logic
// Holds cursors, clip counts, flags and sticky status; computes the result
// of the item presented on fire_i and updates state on that edge.
// ----------------------------------------------------------------------------
module caw_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  caw_pkg::caw_in_t    item_i,
  input  caw_pkg::opc_e       opc_i,
  input  logic [3:0]          digit_i,
  output logic                res_valid_o,
  output caw_pkg::caw_out_t   res_o
);
  import caw_pkg::*;

  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                  input logic [CNT_BITS-1:0] b);
    logic [CNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
  endfunction

  logic [CNT_BITS-1:0] op_count_q, op_count_d;
  logic [POS_BITS-1:0] ref_cursor_q, ref_cursor_d;
  logic [CNT_BITS-1:0] read_cursor_q, read_cursor_d;
  logic [CNT_BITS-1:0] front_clip_q, front_clip_d;
  logic [CNT_BITS-1:0] back_clip_q, back_clip_d;
  logic                seen_align_q, seen_align_d;
  logic                seen_hard_q, seen_hard_d;
  logic [2:0]          err_q, err_d;

  logic [CNT_BITS+3:0] count_x10;
  logic [CNT_BITS-1:0] count_next;
  logic                after_clip;
  logic [POS_BITS-1:0] ref_adv;
  logic [CNT_BITS-1:0] read_adv;
  logic [2:0]          end_status;
  logic                fail;
  logic [2:0]          fail_code;

  // Decimal shift-add: count * 8 + count * 2 + digit, saturated.
  assign count_x10  = {1'b0, op_count_q, 3'b000} + {3'b000, op_count_q, 1'b0}
                    + (CNT_BITS+4)'(digit_i);
  assign count_next = (count_x10[CNT_BITS+3:CNT_BITS] != 4'd0) ? CNT_MAX
                                                              : count_x10[CNT_BITS-1:0];
  assign after_clip = (back_clip_q != '0) || seen_hard_q;
  assign ref_adv    = ref_cursor_q + POS_BITS'(op_count_q);
  assign read_adv   = sat_add(read_cursor_q, op_count_q);
  assign end_status = (err_q == ST_OK && op_count_q != '0) ? ST_TRAILING : err_q;

  always_comb begin
    op_count_d    = op_count_q;
    ref_cursor_d  = ref_cursor_q;
    read_cursor_d = read_cursor_q;
    front_clip_d  = front_clip_q;
    back_clip_d   = back_clip_q;
    seen_align_d  = seen_align_q;
    seen_hard_d   = seen_hard_q;
    err_d         = err_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    fail          = 1'b0;
    fail_code     = ST_OK;

    if (fire_i) begin
      case (item_i.command)
        CMD_BEGIN: begin
          op_count_d    = '0;
          ref_cursor_d  = pos_from_in(item_i.start_position);
          read_cursor_d = '0;
          front_clip_d  = '0;
          back_clip_d   = '0;
          seen_align_d  = 1'b0;
          seen_hard_d   = 1'b0;
          err_d         = ST_OK;
        end
        CMD_END: begin
          err_d            = end_status;
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_SUMMARY;
          res_o.read_pos   = read_cursor_q;
          res_o.ref_pos    = pos_to_out(ref_cursor_q);
          res_o.clip_front = front_clip_q;
          res_o.clip_back  = back_clip_q;
          res_o.status     = end_status;
        end
        CMD_CHAR: begin
          if (err_q == ST_OK) begin
            if (opc_i == OPC_DIGIT) begin
              op_count_d = count_next;
            end else if (op_count_q == '0) begin
              fail      = 1'b1;
              fail_code = ST_NO_COUNT;
            end else begin
              op_count_d = '0;
              case (opc_i)
                OPC_MATCH: begin
                  if (after_clip) begin
                    fail      = 1'b1;
                    fail_code = ST_MATCH_CLIP;
                  end else begin
                    seen_align_d     = 1'b1;
                    res_valid_o      = 1'b1;
                    res_o.kind       = KIND_MAPPED;
                    res_o.read_pos   = read_cursor_q;
                    res_o.ref_pos    = pos_to_out(ref_cursor_q);
                    res_o.run_length = op_count_q;
                    ref_cursor_d     = ref_adv;
                    read_cursor_d    = read_adv;
                  end
                end
                OPC_INSERT: begin
                  if (after_clip) begin
                    fail      = 1'b1;
                    fail_code = ST_INSERT_CLIP;
                  end else begin
                    seen_align_d     = 1'b1;
                    res_valid_o      = 1'b1;
                    res_o.kind       = KIND_UNMAPPED;
                    res_o.read_pos   = read_cursor_q;
                    res_o.run_length = op_count_q;
                    read_cursor_d    = read_adv;
                  end
                end
                OPC_DELETE: begin
                  if (after_clip) begin
                    fail      = 1'b1;
                    fail_code = ST_DELETE_CLIP;
                  end else begin
                    seen_align_d = 1'b1;
                    ref_cursor_d = ref_adv;
                  end
                end
                OPC_SOFT: begin
                  if (seen_hard_q) begin
                    fail      = 1'b1;
                    fail_code = ST_SOFT_HARD;
                  end else begin
                    if (seen_align_q) begin
                      back_clip_d = sat_add(back_clip_q, op_count_q);
                    end else begin
                      front_clip_d = sat_add(front_clip_q, op_count_q);
                    end
                    res_valid_o      = 1'b1;
                    res_o.kind       = KIND_UNMAPPED;
                    res_o.read_pos   = read_cursor_q;
                    res_o.run_length = op_count_q;
                    read_cursor_d    = read_adv;
                  end
                end
                OPC_HARD: begin
                  if (seen_align_q || front_clip_q != '0) begin
                    seen_hard_d = 1'b1;
                  end
                end
                OPC_PAD: begin
                end
                default: begin
                  fail      = 1'b1;
                  fail_code = ST_UNKNOWN_OP;
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase

      // Faults latch the sticky status, drop the count and report.
      if (fail) begin
        err_d        = fail_code;
        op_count_d   = '0;
        res_valid_o  = 1'b1;
        res_o        = '0;
        res_o.kind   = KIND_ERROR;
        res_o.status = fail_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_count_q    <= '0;
      ref_cursor_q  <= '0;
      read_cursor_q <= '0;
      front_clip_q  <= '0;
      back_clip_q   <= '0;
      seen_align_q  <= 1'b0;
      seen_hard_q   <= 1'b0;
      err_q         <= ST_OK;
    end else begin
      op_count_q    <= op_count_d;
      ref_cursor_q  <= ref_cursor_d;
      read_cursor_q <= read_cursor_d;
      front_clip_q  <= front_clip_d;
      back_clip_q   <= back_clip_d;
      seen_align_q  <= seen_align_d;
      seen_hard_q   <= seen_hard_d;
      err_q         <= err_d;
    end
  end

endmodule

/* hdl/cigar_alignment_walker_core.sv */
`timescale 1ns / 1ps
// Path: a result is offered on the output once its item has passed through
//   the input register and then the result register; the result register
//   takes it only while free or emptied by an output transfer.
// Throughput: one item per cycle; the input side stalls only while a result
//   waits in the output register and the output side stalls.
// Reset: asynchronous, active low; clears the walk state (start position 0),
//   the sticky status and both valid flags.
// ----------------------------------------------------------------------------
// cigar_alignment_walker_core: CIGAR string walker top level
// Takes begin, character and end items; emits mapped/unmapped runs, error
// results and an end-of-read summary with clip counts and status.
// ----------------------------------------------------------------------------
module cigar_alignment_walker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  caw_pkg::caw_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output caw_pkg::caw_out_t   out_data_o
);
  import caw_pkg::*;

  // Input register
  logic     in_valid_q;
  caw_in_t  in_q;

  // Result register
  logic     out_valid_q;
  caw_out_t out_q;

  logic     advance;
  logic     in_xfer;
  logic     out_xfer;
  opc_e     opc;
  logic [3:0] digit;
  logic     res_valid;
  caw_out_t res;

  // The held item steps through the walk when the result register is free
  // or is emptied by a transfer this cycle. Items with no result advance too.
  assign advance  = in_valid_q && (!out_valid_q || !out_stall_i);
  assign out_xfer = out_valid_q && !out_stall_i;

  // Stall the input only while the held item cannot advance.
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  caw_decode u_decode (
    .symbol_i (in_q.symbol),
    .opc_o    (opc),
    .digit_o  (digit)
  );

  caw_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (in_q),
    .opc_i       (opc),
    .digit_i     (digit),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: load on every input transfer, drop once advanced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  // Result register: capture a result when the item advances; otherwise
  // clear the valid flag after an output transfer, and hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

endmodule

/* hdl/caw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caw_checker: port-level checks for the CIGAR walker
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module caw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input caw_pkg::caw_out_t   out_data_o
);
  import caw_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // With the output side draining, the input never stalls.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // Runs carry ok status and no clip counts.
  a_run_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_MAPPED || out_data_o.kind == KIND_UNMAPPED)
    |-> out_data_o.status == ST_OK && out_data_o.clip_front == '0
        && out_data_o.clip_back == '0 && out_data_o.run_length != '0)
    else $error("malformed run result");

  // Errors carry a fault code and no run data.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_ERROR
    |-> out_data_o.status != ST_OK && out_data_o.status != ST_TRAILING
        && out_data_o.run_length == '0 && out_data_o.read_pos == '0)
    else $error("malformed error result");

endmodule

bind cigar_alignment_walker_core caw_checker u_caw_checker (.*);

/* bench/cigar_alignment_walker_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_alignment_walker_core_test: self-checking bench for the CIGAR walker
// Feeds begin, character and end transfers built from CIGAR strings (clean
// reads with random counts plus broken and noisy ones), predicts every run,
// error and summary result in the bench, and compares each result field by
// field in order of arrival. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module cigar_alignment_walker_core_test;
  import caw_pkg::*;

  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned READ_ITEMS  = 1500;
  localparam int unsigned DRAIN_EVERY = 400;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned MAX_WAIT    = 13;
  // Command code the block ignores; not part of cmd_e.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    caw_in_t data;
    bit      drain_first;  // hold this transfer until no result is outstanding
  } cigar_item_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  caw_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  caw_out_t out_data_o;

  cigar_alignment_walker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Walk predictor: its own copy of the walker state, all zero after reset.
  // --------------------------------------------------------------------------
  logic [31:0] op_count;
  logic [31:0] ref_cur;
  logic [31:0] read_cur;
  logic [31:0] clip_fr;
  logic [31:0] clip_bk;
  bit          aligned_seen;
  bit          hard_tail_seen;
  status_e     walk_status;

  initial begin
    op_count       = '0;
    ref_cur        = '0;
    read_cur       = '0;
    clip_fr        = '0;
    clip_bk        = '0;
    aligned_seen   = 1'b0;
    hard_tail_seen = 1'b0;
    walk_status    = ST_OK;
  end

  caw_out_t expected_walk_results[$];
  cigar_item_t cigar_items[$];
  int unsigned mismatch_count = 0;
  bit drain_pending = 1'b0;

  // Counts stick at all ones instead of wrapping.
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

  // Latch a sticky fault and build its error result.
  task automatic raise_fault(input status_e code, output caw_out_t res);
    walk_status = code;
    op_count = '0;
    res = '0;
    res.kind = KIND_ERROR;
    res.status = code;
  endtask

  // Advance the predicted walk by one accepted transfer; report at most one
  // result.
  task automatic walk_cigar_item(input caw_in_t it, output bit emits, output caw_out_t res);
    logic [63:0] grown;
    logic [31:0] n;
    bit after_clip;
    emits = 1'b0;
    res = '0;
    case (it.command)
      CMD_BEGIN: begin
        // Clear the walk and load the reference start.
        op_count       = '0;
        ref_cur        = it.start_position;
        read_cur       = '0;
        clip_fr        = '0;
        clip_bk        = '0;
        aligned_seen   = 1'b0;
        hard_tail_seen = 1'b0;
        walk_status    = ST_OK;
      end
      CMD_END: begin
        // A count with no op behind it is only flagged here.
        if (walk_status == ST_OK && op_count != 0) walk_status = ST_TRAILING;
        emits = 1'b1;
        res.kind       = KIND_SUMMARY;
        res.read_pos   = read_cur;
        res.ref_pos    = ref_cur;
        res.clip_front = clip_fr;
        res.clip_back  = clip_bk;
        res.status     = walk_status;
      end
      CMD_CHAR: begin
        // Drop characters while a fault is latched.
        if (walk_status != ST_OK) begin
        end else if (it.symbol >= CH_0 && it.symbol <= CH_9) begin
          grown = 64'(op_count) * 64'd10 + 64'(it.symbol - CH_0);
          op_count = (grown > 64'(CNT_MAX)) ? CNT_MAX : grown[31:0];
        end else if (op_count == 0) begin
          emits = 1'b1;
          raise_fault(ST_NO_COUNT, res);
        end else begin
          n = op_count;
          after_clip = (clip_bk != 0) || hard_tail_seen;
          op_count = '0;
          emits = 1'b1;
          case (it.symbol)
            CH_M, CH_EQ, CH_X: begin
              if (after_clip) begin
                raise_fault(ST_MATCH_CLIP, res);
              end else begin
                aligned_seen   = 1'b1;
                res.kind       = KIND_MAPPED;
                res.read_pos   = read_cur;
                res.ref_pos    = ref_cur;
                res.run_length = n;
                ref_cur        = ref_cur + n;
                read_cur       = sat_add(read_cur, n);
              end
            end
            CH_I: begin
              if (after_clip) begin
                raise_fault(ST_INSERT_CLIP, res);
              end else begin
                aligned_seen   = 1'b1;
                res.kind       = KIND_UNMAPPED;
                res.read_pos   = read_cur;
                res.run_length = n;
                read_cur       = sat_add(read_cur, n);
              end
            end
            CH_D, CH_N: begin
              if (after_clip) begin
                raise_fault(ST_DELETE_CLIP, res);
              end else begin
                emits        = 1'b0;
                aligned_seen = 1'b1;
                ref_cur      = ref_cur + n;
              end
            end
            CH_S: begin
              if (hard_tail_seen) begin
                raise_fault(ST_SOFT_HARD, res);
              end else begin
                if (aligned_seen) clip_bk = sat_add(clip_bk, n);
                else clip_fr = sat_add(clip_fr, n);
                res.kind       = KIND_UNMAPPED;
                res.read_pos   = read_cur;
                res.run_length = n;
                read_cur       = sat_add(read_cur, n);
              end
            end
            CH_H: begin
              // A hard clip only counts as trailing once something came first.
              emits = 1'b0;
              if (aligned_seen || clip_fr != 0) hard_tail_seen = 1'b1;
            end
            CH_P: begin
              emits = 1'b0;
            end
            default: begin
              raise_fault(ST_UNKNOWN_OP, res);
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders. Fields that a command does not use carry random bits.
  // --------------------------------------------------------------------------
  task automatic push_item(logic [1:0] command, logic [31:0] start, logic [7:0] symbol);
    cigar_item_t entry;
    entry.data.command        = command;
    entry.data.start_position = start;
    entry.data.symbol         = symbol;
    entry.drain_first         = drain_pending;
    drain_pending = 1'b0;
    cigar_items = {cigar_items, entry};
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(CMD_CHAR, $urandom(), s[i]);
  endtask

  // Mostly short counts; now and then zero, leading zeros or counts that
  // overflow 32 bits.
  function automatic string count_text();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $sformatf("%0d", $urandom_range(1, 300));
    if (pick < 85) return $sformatf("%0d", $urandom());
    if (pick < 89) return "0";
    if (pick < 94) return $sformatf("00%0d", $urandom_range(1, 99));
    if (pick < 97) return "4294967295";
    return $sformatf("%0d%0d", $urandom_range(42950, 99999), $urandom_range(10000, 99999));
  endfunction

  function automatic logic [31:0] start_text();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 32'h0;
    if (pick < 3) return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    return $urandom();
  endfunction

  // One read: mostly a well-formed CIGAR with random counts, sometimes
  // broken in one place, maybe with a dangling count too, or missing its begin or end.
  task automatic push_random_read();
    string ops;
    int unsigned n_ops;
    int unsigned break_at;
    bit broken;
    ops = "M=XIDNP";
    n_ops = $urandom_range(1, 6);
    broken = ($urandom_range(0, 4) == 0);
    break_at = $urandom_range(0, n_ops + 1);
    if ($urandom_range(0, 9) != 0) push_item(CMD_BEGIN, start_text(), $urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) push_text({count_text(), "H"});
    if ($urandom_range(0, 2) == 0) push_text({count_text(), "S"});
    for (int unsigned i = 0; i <= n_ops + 1; i++) begin
      if (broken && i == break_at) begin
        case ($urandom_range(0, 6))
          0: push_item(CMD_CHAR, $urandom(), $urandom_range(0, 255));
          1: push_text("M");
          2: push_text({count_text(), "S", count_text(), "M"});
          3: push_text({"1H", count_text(), "D"});
          4: push_text({count_text(), "H", count_text(), "S"});
          5: push_text({count_text(), "S", count_text(), "I"});
          default: push_item(CMD_UNUSED, $urandom(), $urandom_range(0, 255));
        endcase
      end
      if (i < n_ops) push_text($sformatf("%s%c", count_text(), ops[$urandom_range(0, 6)]));
    end
    if ($urandom_range(0, 2) == 0) push_text({count_text(), "S"});
    if ($urandom_range(0, 4) == 0) push_text({count_text(), "H"});
    if (broken && $urandom_range(0, 3) == 0) push_text(count_text());
    if ($urandom_range(0, 19) != 0) push_item(CMD_END, $urandom(), $urandom_range(0, 255));
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued transfers with random gaps, predict on accept.
  // --------------------------------------------------------------------------
  int unsigned gap_left = 0;
  bit steady_tx = 1'b0;
  bit walk_emits;
  caw_out_t walk_result;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      // A transfer completed at this edge: advance the predicted walk.
      if (in_valid_i) begin
        walk_cigar_item(in_data_i, walk_emits, walk_result);
        if (walk_emits) expected_walk_results = {expected_walk_results, walk_result};
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cigar_items.size() != 0 &&
                   (!cigar_items[0].drain_first || expected_walk_results.size() == 0)) begin
        in_data_i  <= cigar_items[0].data;
        in_valid_i <= 1'b1;
        cigar_items.pop_front();
        // Alternate long stretches of back-to-back transfers with gappy ones.
        if ($urandom_range(0, 63) == 0) steady_tx = !steady_tx;
        gap_left = steady_tx ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  int unsigned stall_left = 0;
  bit steady_rx = 1'b0;
  caw_out_t oldest_result;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_walk_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data_o);
          mismatch_count++;
        end else begin
          oldest_result = expected_walk_results.pop_front();
          check_field("kind", 32'(oldest_result.kind), 32'(out_data_o.kind));
          check_field("read_pos", oldest_result.read_pos, out_data_o.read_pos);
          check_field("ref_pos", oldest_result.ref_pos, out_data_o.ref_pos);
          check_field("run_length", oldest_result.run_length, out_data_o.run_length);
          check_field("clip_front", oldest_result.clip_front, out_data_o.clip_front);
          check_field("clip_back", oldest_result.clip_back, out_data_o.clip_back);
          check_field("status", 32'(oldest_result.status), 32'(out_data_o.status));
        end
        if ($urandom_range(0, 63) == 0) steady_rx = !steady_rx;
        stall_left = steady_rx ? 0 : $urandom_range(0, MAX_WAIT);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Hard stop in case the block hangs.
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed reads, random reads, then drain and report.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned next_drain;

    // No begin yet: the walk starts from the reset state at reference 0.
    push_text("3S2M");
    // Op with no count, then a character that the sticky fault swallows.
    push_item(CMD_CHAR, 32'h0, 8'hFF);
    push_text("M");
    push_item(CMD_END, 32'hFFFF_FFFF, 8'h00);
    // Top start position wraps; every op character but M and S; trailing hard clip then an
    // insert after it.
    push_item(CMD_BEGIN, 32'hFFFF_FFFF, 8'hFF);
    push_item(CMD_UNUSED, 32'h0, 8'h00);
    push_text("2=1X4D3N1P5H1I");
    push_item(CMD_END, 32'h0, 8'hFF);
    // Count left dangling at the end of the string.
    push_item(CMD_BEGIN, 32'h0, 8'h00);
    push_text("7");
    push_item(CMD_END, 32'h0, 8'h00);

    next_drain = cigar_items.size();
    while (cigar_items.size() < READ_ITEMS + next_drain % DRAIN_EVERY) begin
      if (cigar_items.size() >= next_drain) begin
        drain_pending = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      push_random_read();
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cigar_items.size() != 0 || in_valid_i || expected_walk_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_walk_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time,
               expected_walk_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
